FILE: hw/rtl/bms_pkg.sv
// Shared constants, input word codes and the duty mapping for the buzzer melody sequencer.
package bms_pkg;

  localparam int MAX_NOTES_DEF = 16;

  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int VOL_W   = 7;
  localparam int DUTY_W  = 3;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;

  // Input word kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'd1;

  // Duty is 1 + (volume - 1) * 3 / 99, which steps at 34, 67 and 100.
  function automatic logic [DUTY_W-1:0] duty_of_volume(input logic [VOL_W-1:0] vol);
    logic [DUTY_W-1:0] d;
    if (vol == '0) begin
      d = 3'd0;
    end else if (vol <= 7'd33) begin
      d = 3'd1;
    end else if (vol <= 7'd66) begin
      d = 3'd2;
    end else if (vol <= 7'd99) begin
      d = 3'd3;
    end else begin
      d = 3'd4;
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/buzzer_melody_sequencer_unit.sv
// Top level of the buzzer melody sequencer: note tables, sequencing control and output register.
//
// Usage: each word on the in_ channel is a millisecond tick, a note entry load or a stop.
// Every accepted word yields exactly one word on the out_ channel with the tone now
// sounding (frequency, PWM duty level from 0 to 4, playing flag), in order.
// Note entries land in two single-port tables (frequency and length) of MAX_NOTES entries;
// the entry flagged last starts playback at note 0 if the buzzer is enabled and the
// volume is nonzero. Entries past the table size are dropped.
// Timing: the note length is read at acceptance, then an update step (S_EXEC) updates the
// counters and writes the tables, a read step (S_RDF) reads the frequency of the note now
// current, and a final step (S_OUT) forms the result. The table reads are registered and
// are made only after their write, so no forwarding is needed.
// A new word is accepted only in S_IDLE, so words are taken one at a time, never overlapped.
// The result sits in an output register: the next word is accepted while it waits, and
// the sequencer holds in its final step only if the previous result is still not taken.
// The cfg_ channel (index 0 enable, index 1 volume, clamped to 100) is always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) stops playback, clears the counters, sets enable to 1 and
// volume to 100; table contents are undefined until loaded.
module buzzer_melody_sequencer_unit
  import bms_pkg::*;
#(
  parameter int MAX_NOTES = MAX_NOTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [FREQ_W-1:0]    in_note_frequency,
  input  logic [DUR_W-1:0]     in_note_duration,
  input  logic                 in_is_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FREQ_W-1:0]    out_tone_frequency,
  output logic [DUTY_W-1:0]    out_tone_duty,
  output logic                 out_playing,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOL_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W = $clog2(MAX_NOTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NOTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDF,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Note tables.
  logic [FREQ_W-1:0] freq_mem [MAX_NOTES];
  logic [DUR_W-1:0]  len_mem  [MAX_NOTES];
  logic [FREQ_W-1:0] freq_rd_r;
  logic [DUR_W-1:0]  len_rd_r;

  // Latched input word.
  logic [KIND_W-1:0] kind_r;
  logic [FREQ_W-1:0] nfreq_r;
  logic [DUR_W-1:0]  ndur_r;
  logic              last_r;

  // Sequencer state.
  logic [CNT_W-1:0] melody_len_r, melody_len_nxt;
  logic [CNT_W-1:0] load_pos_r, load_pos_nxt;
  logic [CNT_W-1:0] cur_note_r, cur_note_nxt;
  logic [DUR_W-1:0] elapsed_r, elapsed_nxt;
  logic             active_r, active_nxt;
  logic             enable_r, enable_nxt;
  logic [VOL_W-1:0] volume_r, volume_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [FREQ_W-1:0] out_freq_r, out_freq_nxt;
  logic [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  logic              out_play_r, out_play_nxt;

  logic             in_fire;
  logic             cfg_fire;
  logic             tbl_wr;
  logic [DUR_W-1:0] el_inc;
  logic [CNT_W-1:0] note_inc;
  logic [CNT_W-1:0] pos_inc;
  logic [DUTY_W-1:0] duty;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign out_valid          = out_valid_r;
  assign out_tone_frequency = out_freq_r;
  assign out_tone_duty      = out_duty_r;
  assign out_playing        = out_play_r;

  assign tbl_wr   = (state_r == S_EXEC) && (kind_r == KIND_LOAD) && (load_pos_r < MAX_CNT);
  assign el_inc   = (elapsed_r == {DUR_W{1'b1}}) ? elapsed_r : elapsed_r + DUR_W'(1);
  assign note_inc = cur_note_r + CNT_W'(1);
  assign pos_inc  = (load_pos_r < MAX_CNT) ? load_pos_r + CNT_W'(1) : load_pos_r;
  assign duty     = duty_of_volume(volume_r);

  // Tables: length is read at acceptance, frequency after the update step has written.
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      freq_mem[load_pos_r[IDX_W-1:0]] <= nfreq_r;
      len_mem[load_pos_r[IDX_W-1:0]]  <= ndur_r;
    end
    if (in_fire) begin
      len_rd_r <= len_mem[cur_note_r[IDX_W-1:0]];
    end
    if (state_r == S_RDF) begin
      freq_rd_r <= freq_mem[cur_note_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_kind;
      nfreq_r <= in_note_frequency;
      ndur_r  <= in_note_duration;
      last_r  <= in_is_last;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    melody_len_nxt = melody_len_r;
    load_pos_nxt   = load_pos_r;
    cur_note_nxt   = cur_note_r;
    elapsed_nxt    = elapsed_r;
    active_nxt     = active_r;
    enable_nxt     = enable_r;
    volume_nxt     = volume_r;
    out_valid_nxt  = out_valid_r;
    out_freq_nxt   = out_freq_r;
    out_duty_nxt   = out_duty_r;
    out_play_nxt   = out_play_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration must arrive only while idle, so it never meets an update step; the block does not enforce this.
    if (cfg_fire) begin
      case (cfg_index)
        CFG_ENABLE: begin
          enable_nxt = cfg_data[0];
          if (!cfg_data[0]) begin
            active_nxt   = 1'b0;
            load_pos_nxt = '0;
          end
        end
        CFG_VOLUME: begin
          volume_nxt = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RDF;
        case (kind_r)
          KIND_TICK: begin
            if (active_r) begin
              if (el_inc < len_rd_r) begin
                elapsed_nxt = el_inc;
              end else begin
                elapsed_nxt = '0;
                if (note_inc >= melody_len_r) begin
                  active_nxt   = 1'b0;
                  cur_note_nxt = '0;
                end else begin
                  cur_note_nxt = note_inc;
                end
              end
            end
          end
          KIND_LOAD: begin
            active_nxt   = 1'b0;
            load_pos_nxt = pos_inc;
            if (last_r) begin
              load_pos_nxt = '0;
              // A refused start leaves the old melody length; the loaded entries stay written in the tables.
              if (enable_r && (volume_r != '0)) begin
                melody_len_nxt = pos_inc;
                cur_note_nxt   = '0;
                elapsed_nxt    = '0;
                active_nxt     = (pos_inc != '0);
              end
            end
          end
          KIND_STOP: begin
            active_nxt   = 1'b0;
            load_pos_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_RDF: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_play_nxt  = active_r;
          if (active_r && enable_r && (freq_rd_r != '0) && (duty != '0)) begin
            out_freq_nxt = freq_rd_r;
            out_duty_nxt = duty;
          end else begin
            out_freq_nxt = '0;
            out_duty_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      melody_len_r <= '0;
      load_pos_r   <= '0;
      cur_note_r   <= '0;
      elapsed_r    <= '0;
      active_r     <= 1'b0;
      enable_r     <= 1'b1;
      volume_r     <= VOL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      melody_len_r <= melody_len_nxt;
      load_pos_r   <= load_pos_nxt;
      cur_note_r   <= cur_note_nxt;
      elapsed_r    <= elapsed_nxt;
      active_r     <= active_nxt;
      enable_r     <= enable_nxt;
      volume_r     <= volume_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_freq_r <= out_freq_nxt;
    out_duty_r <= out_duty_nxt;
    out_play_r <= out_play_nxt;
  end

  a_active_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> enable_r)
    else $error("playback active while disabled");

  a_note_in_melody: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_note_r < melody_len_r) && (melody_len_r <= MAX_CNT))
    else $error("current note outside the melody");

  a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    load_pos_r <= MAX_CNT)
    else $error("load position beyond table size");

  a_tone_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_duty_r != '0)) |-> (out_freq_r != '0) && out_play_r
      && (out_duty_r <= 3'd4))
    else $error("sounding tone without frequency or playback");

endmodule
